/* sv/sdspi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_pkg
// shared types and constants for the sd card spi responder
// ----------------------------------------------------------------------------
package sdspi_pkg;

	localparam int unsigned SECTOR_BYTES = 512;
	localparam int unsigned SectorShift  = $clog2(SECTOR_BYTES);

	// access kinds and ports
	localparam logic       KIND_READ   = 1'b0;
	localparam logic       KIND_WRITE  = 1'b1;
	localparam logic [1:0] PORT_LATCH  = 2'd0;
	localparam logic [1:0] PORT_PIN    = 2'd1;
	localparam logic [1:0] PORT_OTHER  = 2'd2;
	localparam logic [1:0] PORT_SPARE  = 2'd3;

	// latch bits
	localparam int unsigned BIT_MOSI = 0;
	localparam int unsigned BIT_SCK  = 1;
	localparam int unsigned BIT_CS_N = 5;
	localparam int unsigned BIT_MISO = 6;

	// commands
	localparam logic [7:0] CMD_GO_IDLE   = 8'h40;
	localparam logic [7:0] CMD_SEND_IF   = 8'h48;
	localparam logic [7:0] CMD_APP       = 8'h77;
	localparam logic [7:0] ACMD_OP_COND  = 8'h69;
	localparam logic [7:0] CMD_READ_OCR  = 8'h7a;
	localparam logic [7:0] CMD_READ_BLK  = 8'h51;

	// reply bytes
	localparam logic [7:0] R1_IDLE      = 8'h01;
	localparam logic [7:0] R1_READY     = 8'h00;
	localparam logic [7:0] TOKEN_START  = 8'hfe;
	localparam logic [7:0] ECHO_VOLTAGE = 8'h01;
	localparam logic [7:0] ECHO_PATTERN = 8'haa;

	typedef struct packed {
		logic        kind;
		logic [1:0]  port;
		logic [15:0] write_data;
		logic [7:0]  image_byte;
	} item_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        port_known;
		logic [31:0] image_address;
	} result_t;

endpackage
`default_nettype wire

/* sv/sdspi_item_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_item_if
// valid/ready channel carrying one bus access
// ----------------------------------------------------------------------------
interface sdspi_item_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [1:0]  port;
	logic [15:0] write_data;
	logic [7:0]  image_byte;

	modport source (output valid, kind, port, write_data, image_byte, input ready);
	modport sink   (input valid, kind, port, write_data, image_byte, output ready);
endinterface
`default_nettype wire

/* sv/sdspi_result_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_result_if
// valid/ready channel carrying one access result
// ----------------------------------------------------------------------------
interface sdspi_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_data;
	logic        port_known;
	logic [31:0] image_address;

	modport source (output valid, read_data, port_known, image_address, input ready);
	modport sink   (input valid, read_data, port_known, image_address, output ready);
endinterface
`default_nettype wire

/* sv/sdspi_card.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_card
// card state and the per-access update: spi shift, command decode, replies
// ----------------------------------------------------------------------------
module sdspi_card
	import sdspi_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    fire,
	input  wire item_t   item,
	output result_t      result
);

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_DUMMY  = 4'd1,
		PH_CMD    = 4'd2,
		PH_ARG3   = 4'd3,
		PH_ARG2   = 4'd4,
		PH_ARG1   = 4'd5,
		PH_ARG0   = 4'd6,
		PH_CRC    = 4'd7,
		PH_R1     = 4'd8,
		PH_R7     = 4'd9,
		PH_SECTOR = 4'd10
	} phase_t;

	logic [15:0] latch_q;
	phase_t      phase_q;
	logic [5:0]  bit_cnt_q;
	logic [7:0]  shift_q;
	logic [7:0]  cmd_q;
	logic [31:0] arg_q;
	logic        app_q;
	logic [7:0]  tx_q;
	logic        echo_q;
	logic [31:0] ptr_q;

	logic [15:0] latch_n;
	phase_t      phase_n;
	logic [5:0]  bit_cnt_n;
	logic [7:0]  shift_n;
	logic [7:0]  cmd_n;
	logic [31:0] arg_n;
	logic        app_n;
	logic [7:0]  tx_n;
	logic        echo_n;
	logic [31:0] ptr_n;

	logic [5:0]  cnt_inc;
	logic [7:0]  shifted;
	logic        replying;
	logic        clocked;

	assign cnt_inc  = bit_cnt_q + 6'd1;
	assign shifted  = {shift_q[6:0], item.write_data[BIT_MOSI]};
	assign replying = (phase_q == PH_R1) || (phase_q == PH_R7) || (phase_q == PH_SECTOR);
	assign clocked  = (item.kind == KIND_WRITE) && (item.port == PORT_LATCH)
		&& !item.write_data[BIT_CS_N] && item.write_data[BIT_SCK];

	always_comb begin
		latch_n   = latch_q;
		phase_n   = phase_q;
		bit_cnt_n = bit_cnt_q;
		shift_n   = shift_q;
		cmd_n     = cmd_q;
		arg_n     = arg_q;
		app_n     = app_q;
		tx_n      = tx_q;
		echo_n    = echo_q;
		ptr_n     = ptr_q;

		if (item.kind == KIND_WRITE && item.port == PORT_LATCH) begin
			latch_n = item.write_data;
			if (item.write_data[BIT_CS_N]) begin
				if (phase_q != PH_IDLE) begin
					app_n   = 1'b0;
					phase_n = PH_IDLE;
				end
			end
		end

		if (clocked) begin
			shift_n = shifted;
			case (phase_q)
				PH_IDLE: begin
					phase_n   = PH_DUMMY;
					bit_cnt_n = 6'd1;
				end
				PH_DUMMY, PH_CMD, PH_ARG3, PH_ARG2, PH_ARG1, PH_ARG0, PH_CRC: begin
					bit_cnt_n = cnt_inc;
					if (cnt_inc == 6'd8) begin
						bit_cnt_n = 6'd0;
						case (phase_q)
							PH_DUMMY: phase_n = PH_CMD;
							PH_CMD: begin
								cmd_n   = shifted;
								phase_n = PH_ARG3;
							end
							PH_ARG3: begin
								arg_n   = {24'd0, shifted};
								phase_n = PH_ARG2;
							end
							PH_ARG2: begin
								arg_n   = {arg_q[23:0], shifted};
								phase_n = PH_ARG1;
							end
							PH_ARG1: begin
								arg_n   = {arg_q[23:0], shifted};
								phase_n = PH_ARG0;
							end
							PH_ARG0: begin
								arg_n   = {arg_q[23:0], shifted};
								phase_n = PH_CRC;
							end
							default: begin
								// crc byte done: decide the command
								case (cmd_q)
									CMD_GO_IDLE: begin
										tx_n    = R1_IDLE;
										phase_n = PH_R1;
									end
									CMD_SEND_IF: begin
										tx_n    = R1_IDLE;
										echo_n  = 1'b1;
										phase_n = PH_R7;
									end
									CMD_APP: begin
										app_n   = 1'b1;
										tx_n    = R1_IDLE;
										phase_n = PH_R1;
									end
									ACMD_OP_COND: begin
										if (app_q) begin
											tx_n    = R1_READY;
											phase_n = PH_R1;
										end
									end
									CMD_READ_OCR: begin
										tx_n    = R1_READY;
										phase_n = PH_R7;
									end
									CMD_READ_BLK: begin
										tx_n    = R1_READY;
										phase_n = PH_SECTOR;
										ptr_n   = {arg_q[31-SectorShift:0], {SectorShift{1'b0}}};
									end
									default: ;
								endcase
							end
						endcase
					end
				end
				PH_R1: begin
					tx_n      = {tx_q[6:0], 1'b0};
					bit_cnt_n = cnt_inc;
					if (cnt_inc == 6'd8) phase_n = PH_IDLE;
				end
				PH_R7: begin
					tx_n      = {tx_q[6:0], 1'b0};
					bit_cnt_n = cnt_inc;
					if (cnt_inc == 6'd8 || cnt_inc == 6'd16) begin
						tx_n = 8'h00;
					end else if (cnt_inc == 6'd24) begin
						tx_n = echo_q ? ECHO_VOLTAGE : 8'h00;
					end else if (cnt_inc == 6'd32) begin
						tx_n = echo_q ? ECHO_PATTERN : 8'h00;
					end else if (cnt_inc == 6'd40) begin
						phase_n = PH_IDLE;
					end
				end
				PH_SECTOR: begin
					tx_n      = {tx_q[6:0], 1'b0};
					bit_cnt_n = cnt_inc;
					if (cnt_inc == 6'd8) begin
						tx_n = TOKEN_START;
					end else if (cnt_inc >= 6'd16) begin
						if (cnt_inc >= 6'd24) bit_cnt_n = 6'd16;
						if (cnt_inc >= 6'd24 || cnt_inc == 6'd16) begin
							tx_n  = item.image_byte;
							ptr_n = ptr_q + 32'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		result.read_data     = 16'd0;
		result.port_known    = 1'b0;
		result.image_address = ptr_n;
		if (item.kind == KIND_READ) begin
			if (item.port == PORT_LATCH) begin
				result.read_data  = latch_q;
				result.port_known = 1'b1;
			end else if (item.port == PORT_PIN) begin
				result.read_data[BIT_MISO] = replying && tx_q[7];
				result.port_known          = 1'b1;
			end
		end else if (item.port == PORT_LATCH) begin
			result.port_known = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q   <= 16'd0;
			phase_q   <= PH_IDLE;
			bit_cnt_q <= 6'd0;
			shift_q   <= 8'd0;
			cmd_q     <= 8'd0;
			arg_q     <= 32'd0;
			app_q     <= 1'b0;
			tx_q      <= 8'd0;
			echo_q    <= 1'b0;
			ptr_q     <= 32'd0;
		end else if (fire) begin
			latch_q   <= latch_n;
			phase_q   <= phase_n;
			bit_cnt_q <= bit_cnt_n;
			shift_q   <= shift_n;
			cmd_q     <= cmd_n;
			arg_q     <= arg_n;
			app_q     <= app_n;
			tx_q      <= tx_n;
			echo_q    <= echo_n;
			ptr_q     <= ptr_n;
		end
	end

endmodule
`default_nettype wire

/* sv/sd_card_spi_bitbang_responder_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sd_card_spi_bitbang_responder_core
// sd card in spi mode answering bit-banged latch and pin port accesses
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------
//  item     | in  | kind, port, write_data, image_byte
//  result   | out | read_data, port_known, image_address
//
//  one transaction per clock while the result channel is not held; each access passes the
//  input register, then the card update and the result register
//  reset clears the card state and the valid flags of the input stage and the result register
//  a held result stalls the input stage only when both registers are full
// ----------------------------------------------------------------------------
module sd_card_spi_bitbang_responder_core
	import sdspi_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	sdspi_item_if.sink    item,
	sdspi_result_if.source result
);

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t out_q;
	result_t card_res;
	logic    advance;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.kind       <= item.kind;
			item_s1.port       <= item.port;
			item_s1.write_data <= item.write_data;
			item_s1.image_byte <= item.image_byte;
		end
	end

	sdspi_card u_card (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.result (card_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_q <= card_res;
	end

	assign result.valid         = out_valid_q;
	assign result.read_data     = out_q.read_data;
	assign result.port_known    = out_q.port_known;
	assign result.image_address = out_q.image_address;

endmodule
`default_nettype wire
